### rtl/core/grid_depth_first_search_core_defines.svh
// ----------------------------------------------------------------------------
// Grid DFS core assertion macros
// Shared concurrent assertion helpers, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef GRID_DEPTH_FIRST_SEARCH_CORE_DEFINES_SVH
`define GRID_DEPTH_FIRST_SEARCH_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define GDFS_ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("gdfs assertion failed");
// antecedent implies consequent in the next cycle
`define GDFS_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("gdfs assertion failed");
// condition never holds
`define GDFS_ASSERT_NEVER(lbl, a) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
    else $error("gdfs assertion failed");
`else
`define GDFS_ASSERT_IMPL(lbl, a, b)
`define GDFS_ASSERT_NEXT(lbl, a, b)
`define GDFS_ASSERT_NEVER(lbl, a)
`endif

`endif

### rtl/core/gdfs_pkg.sv
// ----------------------------------------------------------------------------
// Grid DFS package
// Field widths, opcodes and FSM state codes for the grid DFS core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package gdfs_pkg;

  localparam int CELL_W       = 12;
  localparam int SIDE_CFG_W   = 7;
  localparam int OP_W         = 2;
  localparam int DEF_MAX_SIDE = 64;
  localparam int DIV_CNT_W    = $clog2(CELL_W);
  localparam logic [SIDE_CFG_W-1:0] SIDE_RESET = 7'd64;

  // input opcodes
  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_INIT = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP = 2'd2;

  // memory word of the cell store
  localparam int BLK_BIT = 1;
  localparam int VIS_BIT = 0;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_LD_RD  = 12'b0000_0000_0010,
    S_LD_WR  = 12'b0000_0000_0100,
    S_CLR    = 12'b0000_0000_1000,
    S_IN_RD  = 12'b0000_0001_0000,
    S_IN_WR  = 12'b0000_0010_0000,
    S_POP    = 12'b0000_0100_0000,
    S_POPD   = 12'b0000_1000_0000,
    S_DIV    = 12'b0001_0000_0000,
    S_NB_RD  = 12'b0010_0000_0000,
    S_NB_CHK = 12'b0100_0000_0000,
    S_EMIT   = 12'b1000_0000_0000
  } state_t;

endpackage

### rtl/core/grid_depth_first_search_core.sv
// Grid DFS core: load cells, init search, step one pop at a time.
// Load: read-modify-write of one cell entry. Init: clearing pass over the
//   cell store, one entry per cycle, then mark and push the start cell. Step: pop,
//   bit-serial row/col divide, neighbor read/check on the cell store, then results.
// Results leave as one-cycle out_valid strobes; the receiver cannot stall.
// Synchronous active-low reset clears control, stack count, start/goal cells and done.
`timescale 1ns / 1ps
`include "grid_depth_first_search_core_defines.svh"
module grid_depth_first_search_core #(
  parameter int MAX_SIDE = gdfs_pkg::DEF_MAX_SIDE
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [gdfs_pkg::OP_W-1:0]     in_op,
  input  logic [gdfs_pkg::CELL_W-1:0]   in_cell_index,
  input  logic                          in_cell_blocked,
  input  logic                          in_cell_is_start,
  input  logic                          in_cell_is_goal,
  // result channel
  output logic                          out_valid,
  output logic [gdfs_pkg::CELL_W-1:0]   out_popped_index,
  output logic                          out_discovered_valid,
  output logic [gdfs_pkg::CELL_W-1:0]   out_child_index,
  output logic [gdfs_pkg::CELL_W-1:0]   out_parent_index,
  output logic                          out_done_res,
  output logic                          out_last,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gdfs_pkg::SIDE_CFG_W-1:0] cfg_grid_side
);
  import gdfs_pkg::*;

  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int CNT_W = AW + 1;
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int CW    = CELL_W;

  // memories
  logic [1:0]    cell_mem [CELLS];
  logic [CW-1:0] stk_mem  [CELLS];

  logic          cm_we;
  logic [AW-1:0] cm_waddr, cm_raddr;
  logic [1:0]    cm_wdata, cm_rdata_r;
  logic          sm_we;
  logic [AW-1:0] sm_waddr, sm_raddr;
  logic [CW-1:0] sm_wdata, sm_rdata_r;

  state_t state_r, state_nxt;

  logic [SIDE_CFG_W-1:0] side_cfg_r;
  logic [SW-1:0]         side_eff, side_r;
  logic [CNT_W-1:0]      cnt_r, clr_cnt_r;
  logic [CW-1:0]         start_cell_r, goal_cell_r, v_r, ld_idx_r;
  logic                  ld_blk_r;
  logic                  done_r;
  logic [CW-1:0]         dvd_r;
  logic [SW-1:0]         rem_r;
  logic [DIV_CNT_W-1:0]  div_cnt_r;
  logic [1:0]            nb_i_r;
  logic [CW-1:0]         found_r [4];
  logic [2:0]            nf_r;
  logic [1:0]            k_r;

  logic [CW-1:0] out_pop_r, out_child_r, out_parent_r;
  logic          out_valid_r, out_disc_r, out_done_r, out_last_r;

  // divider step
  logic [SW:0] rem_sh, rem_sub;
  logic        rem_ge;
  // neighbor candidate
  logic          nb_ok;
  logic [CW:0]   nb_cand;
  logic          nb_inmem;
  logic          nb_free;
  logic          emit_last;
  logic [2*SW-1:0] side_sq;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);

  // effective side: zero acts as one, clamp to MAX_SIDE
  always_comb begin
    if (side_cfg_r == '0) begin
      side_eff = SW'(1);
    end else if (32'(side_cfg_r) > MAX_SIDE) begin
      side_eff = SW'(MAX_SIDE);
    end else begin
      side_eff = SW'(side_cfg_r);
    end
  end

  assign side_sq = side_r * side_r;

  assign rem_sh  = {rem_r, dvd_r[CW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, side_r});
  assign rem_sub = rem_ge ? (rem_sh - {1'b0, side_r}) : rem_sh;

  // neighbor order: col-1, col+1, row-1, row+1
  always_comb begin
    case (nb_i_r)
      2'd0: begin
        nb_ok   = (rem_r != '0);
        nb_cand = {1'b0, v_r} - (CW+1)'(1);
      end
      2'd1: begin
        nb_ok   = ((SW+1)'(rem_r) + (SW+1)'(1)) < (SW+1)'(side_r);
        nb_cand = {1'b0, v_r} + (CW+1)'(1);
      end
      2'd2: begin
        nb_ok   = (dvd_r != '0);
        nb_cand = {1'b0, v_r} - (CW+1)'(side_r);
      end
      default: begin
        nb_ok   = ((CW+1)'(dvd_r) + (CW+1)'(1)) < (CW+1)'(side_r);
        nb_cand = {1'b0, v_r} + (CW+1)'(side_r);
      end
    endcase
  end

  assign nb_inmem  = nb_ok && (32'(nb_cand) < CELLS);
  assign nb_free   = !cm_rdata_r[BLK_BIT] && !cm_rdata_r[VIS_BIT];
  assign emit_last = (nf_r == '0) || (3'(k_r) == nf_r - 3'd1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_op)
            OP_LOAD: state_nxt = (32'(in_cell_index) < CELLS) ? S_LD_RD : S_IDLE;
            OP_INIT: state_nxt = S_CLR;
            OP_STEP: state_nxt = S_POP;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LD_RD:  state_nxt = S_LD_WR;
      S_LD_WR:  state_nxt = S_IDLE;
      S_CLR:    state_nxt = (32'(clr_cnt_r) == CELLS) ? S_IN_RD : S_CLR;
      S_IN_RD:  state_nxt = (32'(start_cell_r) < CELLS) ? S_IN_WR : S_IDLE;
      S_IN_WR:  state_nxt = S_IDLE;
      S_POP:    state_nxt = (cnt_r == '0) ? S_EMIT : S_POPD;
      // popped cell outside the grid contributes no neighbors
      S_POPD:   state_nxt = (32'(sm_rdata_r) < 32'(side_sq)) ? S_DIV : S_EMIT;
      S_DIV:    state_nxt = (32'(div_cnt_r) == CW - 1) ? S_NB_RD : S_DIV;
      S_NB_RD: begin
        if (nb_inmem) begin
          state_nxt = S_NB_CHK;
        end else if (nb_i_r == 2'd3) begin
          state_nxt = S_EMIT;
        end
      end
      S_NB_CHK: state_nxt = (nb_i_r == 2'd3) ? S_EMIT : S_NB_RD;
      S_EMIT:   state_nxt = emit_last ? S_IDLE : S_EMIT;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    cm_we    = 1'b0;
    cm_waddr = '0;
    cm_wdata = '0;
    cm_raddr = '0;
    sm_we    = 1'b0;
    sm_waddr = cnt_r[AW-1:0];
    sm_wdata = '0;
    sm_raddr = '0;
    case (state_r)
      S_LD_RD: cm_raddr = AW'(ld_idx_r);
      S_LD_WR: begin
        cm_we    = 1'b1;
        cm_waddr = AW'(ld_idx_r);
        cm_wdata = {ld_blk_r, cm_rdata_r[VIS_BIT]};
      end
      S_CLR: begin
        // read entry n, write back entry n-1 with visited cleared
        cm_raddr = clr_cnt_r[AW-1:0];
        cm_we    = (clr_cnt_r != '0);
        cm_waddr = AW'(clr_cnt_r - CNT_W'(1));
        cm_wdata = {cm_rdata_r[BLK_BIT], 1'b0};
      end
      S_IN_RD: cm_raddr = AW'(start_cell_r);
      S_IN_WR: begin
        cm_we    = 1'b1;
        cm_waddr = AW'(start_cell_r);
        cm_wdata = {cm_rdata_r[BLK_BIT], 1'b1};
        sm_we    = 1'b1;
        sm_waddr = '0;
        sm_wdata = start_cell_r;
      end
      S_POP:    sm_raddr = AW'(cnt_r - CNT_W'(1));
      S_NB_RD:  cm_raddr = AW'(nb_cand);
      S_NB_CHK: begin
        if (nb_free) begin
          cm_we    = 1'b1;
          cm_waddr = AW'(nb_cand);
          cm_wdata = {1'b0, 1'b1};
          sm_we    = (32'(cnt_r) < CELLS);
          sm_wdata = CW'(nb_cand);
        end
      end
      default: ;
    endcase
  end

  // cell store: blocked and visited bits
  always_ff @(posedge clk) begin
    if (cm_we) begin
      cell_mem[cm_waddr] <= cm_wdata;
    end
    cm_rdata_r <= cell_mem[cm_raddr];
  end

  // cell stack
  always_ff @(posedge clk) begin
    if (sm_we) begin
      stk_mem[sm_waddr] <= sm_wdata;
    end
    sm_rdata_r <= stk_mem[sm_raddr];
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      side_cfg_r   <= SIDE_RESET;
      cnt_r        <= '0;
      start_cell_r <= '0;
      goal_cell_r  <= '0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      clr_cnt_r    <= '0;
      div_cnt_r    <= '0;
      nb_i_r       <= '0;
      nf_r         <= '0;
      k_r          <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        side_cfg_r <= cfg_grid_side;
      end
      case (state_r)
        S_IDLE: begin
          ld_idx_r  <= in_cell_index;
          ld_blk_r  <= in_cell_blocked;
          clr_cnt_r <= '0;
          side_r    <= side_eff;
          if (start && in_op == OP_LOAD && 32'(in_cell_index) < CELLS) begin
            if (in_cell_is_start) begin
              start_cell_r <= in_cell_index;
            end else if (in_cell_is_goal) begin
              goal_cell_r <= in_cell_index;
            end
          end
        end
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + CNT_W'(1);
          cnt_r     <= '0;
        end
        S_IN_WR: cnt_r <= CNT_W'(1);
        S_POP: begin
          nf_r <= '0;
          k_r  <= '0;
          v_r  <= '0;
          if (cnt_r == '0) begin
            done_r <= 1'b1;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        S_POPD: begin
          v_r       <= sm_rdata_r;
          dvd_r     <= sm_rdata_r;
          rem_r     <= '0;
          div_cnt_r <= '0;
          nb_i_r    <= '0;
          if (sm_rdata_r == goal_cell_r) begin
            done_r <= 1'b1;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle: row in dvd_r, col in rem_r
          rem_r     <= rem_sub[SW-1:0];
          dvd_r     <= {dvd_r[CW-2:0], rem_ge};
          div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
        end
        S_NB_RD: begin
          if (!nb_inmem) begin
            nb_i_r <= nb_i_r + 2'd1;
          end
        end
        S_NB_CHK: begin
          nb_i_r <= nb_i_r + 2'd1;
          if (nb_free) begin
            found_r[nf_r[1:0]] <= CW'(nb_cand);
            nf_r               <= nf_r + 3'd1;
            if (32'(cnt_r) < CELLS) begin
              cnt_r <= cnt_r + CNT_W'(1);
            end
          end
        end
        S_EMIT: begin
          out_valid_r  <= 1'b1;
          out_pop_r    <= v_r;
          out_disc_r   <= (nf_r != '0);
          out_child_r  <= (nf_r != '0) ? found_r[k_r] : '0;
          out_parent_r <= (nf_r != '0) ? v_r : '0;
          out_done_r   <= done_r;
          out_last_r   <= emit_last;
          k_r          <= k_r + 2'd1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_popped_index     = out_pop_r;
  assign out_discovered_valid = out_disc_r;
  assign out_child_index      = out_child_r;
  assign out_parent_index     = out_parent_r;
  assign out_done_res         = out_done_r;
  assign out_last             = out_last_r;

  // checks
  `GDFS_ASSERT_NEXT(a_beats_contiguous, out_valid_r && !out_last_r, out_valid_r)
  `GDFS_ASSERT_NEVER(a_stack_bound, 32'(cnt_r) > CELLS)
  `GDFS_ASSERT_IMPL(a_child_not_parent, out_valid_r && out_disc_r,
                    out_child_r != out_parent_r)

endmodule
